// File: rtl/bwi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwi_pkg
// Shared widths, constants and types of the bandwidth weighted interleave.
// ----------------------------------------------------------------------------
package bwi_pkg;

   // Node table
   localparam int NODES   = 8;
   localparam int IDX_W   = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int CNT_W   = $clog2(NODES + 1);

   // Field widths
   localparam int BW_W     = 24;
   localparam int NODE_W   = 6;
   localparam int WEIGHT_W = 7;
   localparam int SUM_W    = BW_W + ((NODES > 1) ? $clog2(NODES) : 1);

   // Divider operands: numerator bw*200 + sum, denominator 2*sum
   localparam int WEIGHT_SCALE = 100;
   localparam int NUM_W        = BW_W + 9;
   localparam int DEN_W        = SUM_W + 1;
   localparam int CMP_W        = DEN_W + WEIGHT_W;
   localparam int QCNT_W       = $clog2(WEIGHT_W);

   // Stream payload widths
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 16;

   // Register file
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_MIN_BANDWIDTH = 1'b0;
   localparam logic [BW_W-1:0] MIN_BANDWIDTH_RESET = BW_W'(1);

   // Divider status toward the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// File: rtl/bwi_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwi_divider
// Restoring divider, one quotient bit per cycle. The quotient is known to
// fit WEIGHT_W bits, so only WEIGHT_W steps are run.
// ----------------------------------------------------------------------------
module bwi_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [bwi_pkg::NUM_W-1:0]      numer,
   input  logic [bwi_pkg::DEN_W-1:0]      denom,
   output bwi_pkg::div_status_type        status,
   output logic [bwi_pkg::WEIGHT_W-1:0]   quotient
);
   import bwi_pkg::*;

   logic [CMP_W-1:0]    rem_ff, rem_in;
   logic [CMP_W-1:0]    dsh_ff, dsh_in;
   logic [WEIGHT_W-1:0] q_ff, q_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic                ge;

   // One compare and subtract per step
   assign ge = (rem_ff >= dsh_ff);

   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = CMP_W'(numer);
         dsh_in  = CMP_W'(denom) << (WEIGHT_W - 1);
         q_in    = '0;
         cnt_in  = QCNT_W'(WEIGHT_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (ge) begin
            rem_in = rem_ff - dsh_ff;
         end
         q_in   = {q_ff[WEIGHT_W-2:0], ge};
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff - QCNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = q_ff;

endmodule

// File: rtl/bandwidth_weighted_interleave.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bandwidth_weighted_interleave
// Loads one record per memory node, sums the bandwidth of qualifying nodes and
// after the last record emits one interleave weight per node (percent or 0/1).
// ----------------------------------------------------------------------------
// Channel  Ports   Direction  Contents
// req      req_*   in         node record; tlast marks the last node
// rsp      rsp_*   out        node weight; tlast marks the final result
// csr      csr_*   in/out     min_bandwidth at byte address 0
//
// Records load at one per cycle while req_tready is high.
// After the last record: a mode check, then per node a prepare step and,
// for a node that needs a division, a multiply and the 7-step divider
// before rsp_tvalid; each result then holds until rsp_tready is high.
// req_tready stays low from the last record until the final result is taken.
// Synchronous active-high reset; the node table holds no reset value.
// ----------------------------------------------------------------------------
module bandwidth_weighted_interleave (
   input  logic                             clock,
   input  logic                             reset,
   // req_tdata: in_allowed_set[0], bandwidth_idle[1], capacity_idle[2],
   //            max_bandwidth[26:3], zero fill [31:27]
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [bwi_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                             req_tlast,
   // rsp_tdata: node_index[5:0], weight[12:6], selected[13],
   //            equal_mode[14], zero fill [15]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [bwi_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                             rsp_tlast,
   // Register port
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [bwi_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [bwi_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [bwi_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);
   import bwi_pkg::*;

   typedef enum logic [2:0] {
      S_LOAD,
      S_CHECK,
      S_PREP,
      S_MUL,
      S_DSTART,
      S_DWAIT,
      S_OUT
   } state_type;

   state_type           state_ff, state_in;
   logic [BW_W-1:0]     min_bw_ff;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [CNT_W-1:0]    loaded_ff, loaded_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic                equal_ff, equal_in;
   logic [NUM_W-1:0]    numer_ff, numer_in;
   logic [RSP_DATA_W-1:0] data_ff, data_in;
   logic                last_ff, last_in;

   logic [BW_W-1:0]     node_bw_ff [NODES];
   logic                counts_ff [NODES];
   logic                allowed_idle_ff [NODES];

   logic                req_acc, rsp_acc, csr_wr;
   logic                store;
   logic                rec_idle_ok, rec_counts;
   logic [BW_W-1:0]     rec_bw;
   logic                idx_last;
   logic                div_start;
   div_status_type      div_status;
   logic [WEIGHT_W-1:0] div_q;

   // Handshakes
   assign req_tready = (state_ff == S_LOAD);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_acc    = rsp_tvalid && rsp_tready;
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Register file
   always_ff @(posedge clock) begin
      if (reset) begin
         min_bw_ff <= MIN_BANDWIDTH_RESET;
      end else if (csr_wr && (csr_paddr[2] == REG_MIN_BANDWIDTH)) begin
         min_bw_ff <= csr_pwdata[BW_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == REG_MIN_BANDWIDTH) begin
         csr_prdata = CSR_DATA_W'(min_bw_ff);
      end
   end

   // Record qualification
   assign rec_bw      = req_tdata[BW_W+2:3];
   assign rec_idle_ok = req_tdata[0] && req_tdata[1] && req_tdata[2];
   assign rec_counts  = rec_idle_ok && (rec_bw >= min_bw_ff);
   assign store       = req_acc && (loaded_ff < CNT_W'(NODES));

   // Node table
   always_ff @(posedge clock) begin
      if (store) begin
         node_bw_ff[loaded_ff[IDX_W-1:0]]      <= rec_bw;
         counts_ff[loaded_ff[IDX_W-1:0]]       <= rec_counts;
         allowed_idle_ff[loaded_ff[IDX_W-1:0]] <= rec_idle_ok;
      end
   end

   assign idx_last  = ((CNT_W'(idx_ff) + CNT_W'(1)) == loaded_ff);
   assign div_start = (state_ff == S_DSTART);

   bwi_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (numer_ff),
      .denom    ({sum_ff, 1'b0}),
      .status   (div_status),
      .quotient (div_q)
   );

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      sum_in    = sum_ff;
      loaded_in = loaded_ff;
      idx_in    = idx_ff;
      equal_in  = equal_ff;
      numer_in  = numer_ff;
      data_in   = data_ff;
      last_in   = last_ff;
      unique case (state_ff)
         S_LOAD: begin
            if (store) begin
               loaded_in = loaded_ff + CNT_W'(1);
               if (rec_counts) begin
                  sum_in = sum_ff + SUM_W'(rec_bw);
               end
            end
            if (req_acc && req_tlast) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            equal_in = (sum_ff == '0) || (sum_ff < SUM_W'(min_bw_ff));
            idx_in   = '0;
            state_in = S_PREP;
         end
         S_PREP: begin
            last_in = idx_last;
            if (!equal_ff && counts_ff[idx_ff]) begin
               state_in = S_MUL;
            end else begin
               data_in = {1'b0, equal_ff, equal_ff && allowed_idle_ff[idx_ff],
                          WEIGHT_W'(equal_ff && allowed_idle_ff[idx_ff]),
                          NODE_W'(idx_ff)};
               state_in = S_OUT;
            end
         end
         S_MUL: begin
            numer_in = NUM_W'(node_bw_ff[idx_ff]) * NUM_W'(2 * WEIGHT_SCALE)
                       + NUM_W'(sum_ff);
            state_in = S_DSTART;
         end
         S_DSTART: begin
            state_in = S_DWAIT;
         end
         S_DWAIT: begin
            if (div_status.done) begin
               data_in  = {1'b0, 1'b0, 1'b1, div_q, NODE_W'(idx_ff)};
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_acc) begin
               if (last_ff) begin
                  loaded_in = '0;
                  sum_in    = '0;
                  state_in  = S_LOAD;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = S_PREP;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      equal_ff <= equal_in;
      numer_ff <= numer_in;
      data_ff  <= data_in;
      last_ff  <= last_in;
      if (reset) begin
         state_ff  <= S_LOAD;
         sum_ff    <= '0;
         loaded_ff <= '0;
      end else begin
         state_ff  <= state_in;
         sum_ff    <= sum_in;
         loaded_ff <= loaded_in;
      end
   end

   assign rsp_tdata = data_ff;
   assign rsp_tlast = last_ff;

   // Checks
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input accepted while a result is pending");

   a_weight_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (data_ff[NODE_W+WEIGHT_W-1:NODE_W] <= WEIGHT_W'(WEIGHT_SCALE)))
      else $error("weight above 100");

   a_equal_weight: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && data_ff[NODE_W+WEIGHT_W+1])
         |-> (data_ff[NODE_W+WEIGHT_W-1:NODE_W] <= WEIGHT_W'(1)))
      else $error("equal mode weight above 1");

   a_unselected_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !data_ff[NODE_W+WEIGHT_W])
         |-> (data_ff[NODE_W+WEIGHT_W-1:NODE_W] == '0))
      else $error("unselected node with nonzero weight");

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOAD) |-> !div_status.busy)
      else $error("divider busy while loading");

endmodule
